/* hdl/mep_pkg.sv */
// Package: shared constants and types for the Mandelbrot escape-time core.
`default_nettype none
package mep_pkg;
  localparam int IterLimit = 256;
  localparam int IterShift = $clog2(IterLimit);
  localparam int CntW = 9;
  localparam int DatW = 32;
  localparam int ProdW = 64;
  localparam int DivW = 48;
  localparam int ColorTop = 13;

  localparam logic [1:0] CfgSide  = 2'd0;
  localparam logic [1:0] CfgLower = 2'd1;
  localparam logic [1:0] CfgUpper = 2'd2;
  localparam logic [1:0] CfgEsc   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MULC, S_WAITC, S_DIVC, S_NEXTC, S_MUL, S_UPD, S_DONE
  } state_t;

  function automatic logic signed [DatW-1:0] sat32(input logic signed [ProdW-1:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DatW-1:0];
  endfunction
endpackage
`default_nettype wire

/* hdl/mep_sermul.sv */
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
`default_nettype none
module mep_sermul import mep_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [DatW-1:0]  a,
  input  wire logic signed [DatW-1:0]  b,
  output logic                         busy,
  output logic signed [ProdW-1:0]      prod
);
  logic [5:0] cnt_r;
  logic signed [ProdW-1:0] acc_r, mc_r;
  logic [DatW-1:0] mp_r;
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      acc_r <= '0;
      mc_r <= ProdW'(a);
      mp_r <= b;
      cnt_r <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        if (cnt_r == 6'(DatW-1)) acc_r <= acc_r - mc_r;
        else acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'(DatW-1)) busy_r <= 1'b0;
    end
  end
  assign busy = busy_r | start;
  assign prod = acc_r;
endmodule
`default_nettype wire

/* hdl/mandelbrot_escape_pixel_core.sv */
// Top level: Mandelbrot escape-time pixel core.
`default_nettype none
// One pixel item in, one result item out. Each coordinate is formed with a
// bit-serial multiplier (a launch in S_MULC, then S_WAITC until the product
// is taken) and a restoring divider producing one quotient bit per cycle
// (S_DIVC), then stored in S_NEXTC. Each iteration runs the three products
// xx, yy, xy in parallel bit-serial multipliers: a round is a launch
// (S_MUL), the multiply, and a test-and-update (S_UPD). The squares of a
// round also give the escape test of the z formed by the round before, so
// an item that escapes with count n needs n+2 rounds and one at the
// iteration limit needs 257. S_DONE moves the result to the output register
// once it is free, and the core then returns to S_IDLE to take the next
// item. One item is worked at a time; the output register holds a result
// until taken while the next item is worked.
module mandelbrot_escape_pixel_core import mep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_pixel_row,
  input  wire logic [11:0] in_pixel_column,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_color_index,
  output logic [8:0]       out_iteration_count,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [12:0] side_r;
  logic signed [31:0] lower_r, upper_r;
  logic [6:0] esc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= 13'd512; lower_r <= -32'sd33554432;
      upper_r <= 32'sd33554432; esc_r <= 7'd16;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgSide:  side_r <= cfg_data[12:0];
        CfgLower: lower_r <= cfg_data;
        CfgUpper: upper_r <= cfg_data;
        CfgEsc:   esc_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [11:0] row_r, col_r;
  logic sel_r;            // 0: column (real), 1: row (imag)
  logic signed [31:0] cx_r, cy_r, x_r, y_r;
  logic [CntW-1:0] n_r;    // rounds done; final count once finished
  logic [5:0] dcnt_r;
  logic [DivW-1:0] dq_r;   // dividend magnitude shifting into quotient
  logic [13:0] drem_r;
  logic dneg_r;
  logic out_valid_r;
  logic [3:0] color_r;
  logic [CntW-1:0] cnt_out_r;

  // shared multiplier operands
  logic m_start;
  logic signed [31:0] ma0, mb0, ma1, ma2, mb2;
  logic b0, b1, b2;
  logic signed [63:0] p0, p1, p2;
  mep_sermul u_m0 (.clk, .rst_n, .start(m_start), .a(ma0), .b(mb0), .busy(b0), .prod(p0));
  mep_sermul u_m1 (.clk, .rst_n, .start(m_start), .a(ma1), .b(ma1), .busy(b1), .prod(p1));
  mep_sermul u_m2 (.clk, .rst_n, .start(m_start), .a(ma2), .b(mb2), .busy(b2), .prod(p2));

  logic mul_idle_w;
  assign mul_idle_w = !b0 && !b1 && !b2;

  logic signed [32:0] range_w;
  assign range_w = 33'(upper_r) - 33'(lower_r);
  logic [12:0] side_w;
  assign side_w = (side_r == 13'd0) ? 13'd1 : side_r;
  logic [11:0] idx_w;
  assign idx_w = sel_r ? row_r : col_r;

  // escape test on squares of the current z (formed by the previous round)
  logic [63:0] mag_w, bound_w;
  assign mag_w = $unsigned(p0) + $unsigned(p1);
  assign bound_w = 64'({esc_r, 48'd0});
  logic escaped_w, finish_w;
  assign escaped_w = (n_r != '0) && (mag_w > bound_w);
  assign finish_w = escaped_w || (n_r == CntW'(IterLimit));

  logic out_free_w;
  assign out_free_w = !out_valid_r || !out_stall;

  always_comb begin
    m_start = 1'b0;
    ma0 = x_r; mb0 = x_r; ma1 = y_r; ma2 = x_r; mb2 = y_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MULC;
      S_MULC:  begin
        m_start = 1'b1;
        ma0 = {20'd0, idx_w};
        mb0 = range_w[32:1];
        state_nxt = S_WAITC;
      end
      S_WAITC: if (!b0) state_nxt = S_DIVC;
      S_DIVC:  if (dcnt_r == 6'(DivW-1)) state_nxt = S_NEXTC;
      S_NEXTC: state_nxt = sel_r ? S_MUL : S_MULC;
      S_MUL:   begin m_start = 1'b1; state_nxt = S_UPD; end
      S_UPD:   if (mul_idle_w) state_nxt = finish_w ? S_DONE : S_MUL;
      S_DONE:  if (out_free_w) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // index*range = index*(range>>1)*2 + index*range[0]; range needs 33 bits.
  logic signed [63:0] cprod_w;
  assign cprod_w = (p0 <<< 1) + (range_w[0] ? 64'(idx_w) : 64'd0);

  logic signed [63:0] nx_w, ny_w;
  assign nx_w = ((p0 - p1) >>> 24) + 64'(cx_r);
  assign ny_w = (p2 >>> 23) + 64'(cy_r);

  logic [14:0] dtry_w;
  assign dtry_w = {drem_r, dq_r[DivW-1]} - {2'b0, side_w};

  logic signed [63:0] cv_w;
  assign cv_w = 64'(lower_r) + (dneg_r ? -64'(dq_r) : 64'(dq_r));

  // palette: 0 at the limit, else ColorTop - floor(ColorTop*n/IterLimit)
  logic [12:0] c13_w;
  assign c13_w = 13'(n_r) * 13'(ColorTop);
  logic [3:0] color_w;
  assign color_w = (n_r == CntW'(IterLimit)) ? 4'd0
                   : 4'(ColorTop) - 4'(c13_w >> IterShift);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      S_IDLE: if (in_valid) begin
        row_r <= in_pixel_row; col_r <= in_pixel_column;
        sel_r <= 1'b0; n_r <= '0;
      end
      S_WAITC: if (!b0) begin
        dneg_r <= cprod_w[63];
        dq_r <= cprod_w[63] ? DivW'(-cprod_w) : DivW'(cprod_w);
        drem_r <= '0;
        dcnt_r <= '0;
      end
      S_DIVC: begin
        if (!dtry_w[14]) begin
          drem_r <= dtry_w[13:0]; dq_r <= {dq_r[DivW-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[12:0], dq_r[DivW-1]}; dq_r <= {dq_r[DivW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 6'd1;
      end
      S_NEXTC: begin
        if (sel_r) begin cy_r <= sat32(cv_w); y_r <= sat32(cv_w); end
        else begin cx_r <= sat32(cv_w); x_r <= sat32(cv_w); end
        sel_r <= 1'b1;
      end
      S_UPD: if (mul_idle_w) begin
        // an escape found now belongs to the previous round
        if (finish_w) begin
          if (escaped_w) n_r <= n_r - CntW'(1);
        end else begin
          x_r <= sat32(nx_w); y_r <= sat32(ny_w);
          n_r <= n_r + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register: frees the core while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free_w) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == S_DONE && out_free_w) begin
      cnt_out_r <= n_r;
      color_r <= color_w;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_color_index = color_r;
  assign out_iteration_count = cnt_out_r;
endmodule
`default_nettype wire

/* bench/mandelbrot_escape_pixel_checker.sv */
// Checker: shadows the configuration, predicts each pixel's result and compares.
module mandelbrot_escape_pixel_checker import mep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [11:0] in_pixel_row,
  input  wire logic [11:0] in_pixel_column,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_color_index,
  input  wire logic [8:0]  out_iteration_count,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [3:0] color;
    logic [8:0] count;
  } escape_t;

  logic [12:0]       side_q;
  logic signed [31:0] lower_q, upper_q;
  logic [6:0]        esc_q;
  escape_t           expected_q[$];
  int                mismatches;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] pixel_coord(input logic [11:0] idx);
    logic signed [63:0] range, side, prod;
    range = 64'(upper_q) - 64'(lower_q);
    side  = (side_q == 0) ? 64'sd1 : $signed({51'd0, side_q});
    prod  = $signed({52'd0, idx}) * range;
    return clamp32(64'(lower_q) + prod / side);
  endfunction

  function automatic escape_t escape_time(input logic [11:0] row, input logic [11:0] col);
    logic signed [31:0] cx, cy, x, y;
    logic signed [63:0] xx, yy, xy;
    logic [63:0]        mag, bound;
    int                 n;
    escape_t            r;
    cy = pixel_coord(row);
    cx = pixel_coord(col);
    x = cx;
    y = cy;
    bound = {57'd0, esc_q} << 48;
    n = 0;
    while (n < IterLimit) begin
      xx = 64'(x) * 64'(x);
      yy = 64'(y) * 64'(y);
      xy = 64'(x) * 64'(y);
      x = clamp32(((xx - yy) >>> 24) + 64'(cx));
      y = clamp32((xy >>> 23) + 64'(cy));
      mag = 64'(64'(x) * 64'(x)) + 64'(64'(y) * 64'(y));
      if (mag > bound) break;
      n++;
    end
    r.color = (n == IterLimit) ? 4'd0 : 4'(13 - (13 * n) / IterLimit);
    r.count = n[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    escape_t e;
    if (!rst_n) begin
      side_q  <= 13'd512;
      lower_q <= -32'sd33554432;
      upper_q <= 32'sd33554432;
      esc_q   <= 7'd16;
      fail_count = 0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CfgSide:  side_q  <= cfg_data[12:0];
          CfgLower: lower_q <= cfg_data;
          CfgUpper: upper_q <= cfg_data;
          CfgEsc:   esc_q   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(escape_time(in_pixel_row, in_pixel_column));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (mismatches++ < 10) $display("unexpected result: color %0d count %0d",
                                          out_color_index, out_iteration_count);
        end else begin
          e = expected_q.pop_front();
          if (e.color !== out_color_index || e.count !== out_iteration_count) begin
            fail_count++;
            if (mismatches++ < 10)
              $display("mismatch: color exp %0d got %0d, count exp %0d got %0d",
                       e.color, out_color_index, e.count, out_iteration_count);
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

/* bench/mandelbrot_escape_pixel_core_tb.sv */
// Testbench top: drives pixel items and configuration, gives the verdict.
module mandelbrot_escape_pixel_core_tb import mep_pkg::*;;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pixel_row = '0;
  logic [11:0] in_pixel_column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_color_index;
  logic [8:0]  out_iteration_count;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CfgSide;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending;
  int          burst_left;
  int          idle_cycles = 0;
  logic [12:0] side_now;

  // Watchdog limit: a wide margin over the time an item at the iteration
  // limit takes, plus receiver stalls.
  localparam int StallLimit = 100000;

  mandelbrot_escape_pixel_core dut (.*);

  mandelbrot_escape_pixel_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver stall pattern: long free stretches, then runs of random stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_phase < 40) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) != 0);
  end

  // Watchdog: cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CfgSide) side_now = val[12:0];
  endtask

  // Waits for every expected result, then lets the core settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(input logic [12:0] side, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [6:0] esc);
    drain();
    write_reg(CfgSide, {19'd0, side});
    write_reg(CfgLower, lo);
    write_reg(CfgUpper, hi);
    write_reg(CfgEsc, {25'd0, esc});
  endtask

  // Sends one item; valid stays high across a burst, may drop for a random gap after it.
  task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
    in_valid        <= 1'b1;
    in_pixel_row    <= row;
    in_pixel_column <= col;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [11:0] pick_index();
    int lim;
    lim = (side_now == 0) ? 1 : side_now;
    if (lim > 4096) lim = 4096;
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, lim - 1));
  endfunction

  task automatic random_pixels(input int count);
    repeat (count) send_pixel(pick_index(), pick_index());
  endtask

  initial begin
    burst_left = 0;
    side_now = 13'd512;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: grid corners, the origin (never escapes),
    // indexes beyond the side length, field extremes.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd256, 12'd256);
    send_pixel(12'd511, 12'd511);
    send_pixel(12'd512, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd256, 12'd100);
    send_pixel(12'd300, 12'd160);
    send_pixel(12'd2730, 12'd1365);

    // Zero side length, inverted bounds, zero escape limit.
    configure(13'd0, 32'sd16777216, -32'sd16777216, 7'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd4095);
    send_pixel(12'd4095, 12'd2048);
    // Extreme bounds, side of 4096, largest escape limit: saturation.
    configure(13'd4096, 32'h80000000, 32'h7fffffff, 7'd127);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    // Side of one: every index at or beyond the side.
    configure(13'd1, -32'sd16777216, 32'sd16777216, 7'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd3);
    send_pixel(12'd4095, 12'd0);

    // Random phases over several settings.
    configure(13'd64, -32'sd33554432, 32'sd33554432, 7'd16);
    random_pixels(140);
    configure(13'd4096, 32'h80000000, 32'h7fffffff, 7'd127);
    random_pixels(40);
    configure(13'd1, 32'sd16777216, -32'sd16777216, 7'd0);
    random_pixels(30);
    configure(13'd0, -32'sd25165824, 32'sd8388608, 7'd4);
    random_pixels(50);
    configure(13'd200, -32'sd12582912, 32'sd4194304, 7'd1);
    random_pixels(120);
    configure(13'd4095, -32'sd50331648, 32'sd8388608, 7'd100);
    random_pixels(50);

    drain();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
